// File: hw/rtl/expression_token_scanner_top_macros.svh
// Assertion macros for the expression token scanner.
// Uses the clock and reset names of the module that includes it.
`ifndef EXPRESSION_TOKEN_SCANNER_TOP_MACROS_SVH
`define EXPRESSION_TOKEN_SCANNER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// check while out of reset
`define ETS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check across reset as well
`define ETS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ETS_ASSERT(lbl, prop, msg)
`define ETS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/ets_pkg.sv
// Package for the expression token scanner: widths, codes, character
// constants, result word layout and character class functions. No dependencies.
package ets_pkg;

   localparam int POS_BITS     = 16;
   localparam int OUT_POS_BITS = 16;
   localparam int RES_MAX      = 3;
   localparam int FIFO_DEPTH   = 4;
   localparam int PTR_BITS     = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS     = $clog2(FIFO_DEPTH + 1);
   localparam int NRES_BITS    = $clog2(RES_MAX + 1);

   typedef logic [POS_BITS-1:0]     pos_type;
   typedef logic [OUT_POS_BITS-1:0] out_pos_type;
   typedef logic [PTR_BITS-1:0]     ptr_type;
   typedef logic [CNT_BITS-1:0]     cnt_type;
   typedef logic [NRES_BITS-1:0]    nres_type;
   typedef logic [7:0]              char_type;
   typedef logic [3:0]              kind_type;
   typedef logic [1:0]              err_type;

   localparam pos_type POS_MAX = '1;

   typedef enum logic [4:0] {
      MODE_IDLE  = 5'b00001,
      MODE_NUM   = 5'b00010,
      MODE_IDENT = 5'b00100,
      MODE_DOT   = 5'b01000,
      MODE_DROP  = 5'b10000
   } mode_type;

   localparam kind_type KIND_NUMBER = 4'd0;
   localparam kind_type KIND_IDENT  = 4'd1;
   localparam kind_type KIND_PLUS   = 4'd2;
   localparam kind_type KIND_MINUS  = 4'd3;
   localparam kind_type KIND_STAR   = 4'd4;
   localparam kind_type KIND_CARET  = 4'd5;
   localparam kind_type KIND_LPAREN = 4'd6;
   localparam kind_type KIND_RPAREN = 4'd7;
   localparam kind_type KIND_COMMA  = 4'd8;
   localparam kind_type KIND_COLON  = 4'd9;
   localparam kind_type KIND_EQUAL  = 4'd10;
   localparam kind_type KIND_CMD    = 4'd11;
   localparam kind_type KIND_SLASH  = 4'd12;
   localparam kind_type KIND_END    = 4'd13;
   localparam kind_type KIND_ERROR  = 4'd14;

   localparam err_type ERR_NONE = 2'd0;
   localparam err_type ERR_CHAR = 2'd1;
   localparam err_type ERR_LONG = 2'd2;

   localparam char_type CH_DOT    = 8'h2E;
   localparam char_type CH_UNDER  = 8'h5F;
   localparam char_type CH_SLASH  = 8'h2F;
   localparam char_type CH_PLUS   = 8'h2B;
   localparam char_type CH_MINUS  = 8'h2D;
   localparam char_type CH_STAR   = 8'h2A;
   localparam char_type CH_CARET  = 8'h5E;
   localparam char_type CH_LPAREN = 8'h28;
   localparam char_type CH_RPAREN = 8'h29;
   localparam char_type CH_COMMA  = 8'h2C;
   localparam char_type CH_COLON  = 8'h3A;
   localparam char_type CH_EQUAL  = 8'h3D;
   localparam char_type CH_ZERO   = 8'h30;
   localparam char_type CH_NINE   = 8'h39;
   localparam char_type CH_LO_A   = 8'h61;
   localparam char_type CH_LO_Z   = 8'h7A;
   localparam char_type CH_UP_A   = 8'h41;
   localparam char_type CH_UP_Z   = 8'h5A;
   localparam char_type CH_TAB    = 8'h09;
   localparam char_type CH_CR     = 8'h0D;
   localparam char_type CH_SPACE  = 8'h20;

   typedef struct packed {
      kind_type    kind;
      err_type     err;
      out_pos_type start_pos;
      out_pos_type end_pos;
      char_type    bad;
      logic        last;
   } res_type;

   function automatic logic is_digit(char_type c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic is_head(char_type c);
      return (c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]}) || (c == CH_UNDER);
   endfunction

   function automatic logic is_tail(char_type c);
      return is_head(c) || is_digit(c);
   endfunction

   function automatic logic is_space(char_type c);
      return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
   endfunction

   function automatic logic is_op(char_type c);
      return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_CARET, CH_LPAREN, CH_RPAREN,
                       CH_COMMA, CH_COLON, CH_EQUAL, CH_SLASH};
   endfunction

   // kind of a one-character operator other than slash
   function automatic kind_type op_kind(char_type c);
      kind_type k;
      case (c)
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_STAR:   k = KIND_STAR;
         CH_CARET:  k = KIND_CARET;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_COMMA:  k = KIND_COMMA;
         CH_COLON:  k = KIND_COLON;
         CH_EQUAL:  k = KIND_EQUAL;
         default:   k = KIND_NUMBER;
      endcase
      return k;
   endfunction

   // build one result word; positions are cut or widened to the port width
   function automatic res_type make_res(kind_type k, err_type e, pos_type s,
                                        pos_type p, char_type b);
      res_type r;
      r.kind      = k;
      r.err       = e;
      r.start_pos = out_pos_type'(s);
      r.end_pos   = out_pos_type'(p);
      r.bad       = b;
      r.last      = 1'b0;
      return r;
   endfunction

endpackage

// File: hw/rtl/expression_token_scanner_top.sv
// Expression token scanner top level: scanner state and result queue.
// Depends on ets_pkg and expression_token_scanner_top_macros.svh.
//
// Usage: one character word per req_ handshake (req_valid high, req_stall
// low at a rising edge); token words leave on the rsp_ channel the same way.
// Each character yields zero to three token words: a finished number or
// identifier, an operator or an error word, and an end word on the last
// character of a string. The character is scanned in the cycle it is
// accepted and its words are written into a four-entry result queue at the
// next rising edge; they leave in order, one per cycle while rsp_stall is low.
// Throughput is one character per cycle while each character yields at most
// one word and rsp_stall stays low; req_stall rises whenever the queue holds
// more than one word, which is the room a three-word burst needs.
// When the receiver holds rsp_stall, the current word stays on the rsp_ ports
// and characters are still taken while the queue holds at most one word.
// Synchronous reset empties the queue and puts the scanner at the start of a
// new string at position zero.
module expression_token_scanner_top
   import ets_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_start_pos,
   output logic [15:0] rsp_end_pos,
   output logic [7:0]  rsp_bad_char,
   output logic        rsp_last_of_run
);

`include "expression_token_scanner_top_macros.svh"

   localparam cnt_type ACCEPT_LIMIT = cnt_type'(FIFO_DEPTH - RES_MAX);

   // scanner state
   mode_type mode_ff, mode_in;
   logic     dot_ff, dot_in;
   pos_type  tok_start_ff, tok_start_in;
   pos_type  char_pos_ff, char_pos_in;
   logic     emitted_ff, emitted_in;

   // result queue
   res_type  fifo_ff [FIFO_DEPTH];
   ptr_type  wr_ptr_ff, wr_ptr_in;
   ptr_type  rd_ptr_ff, rd_ptr_in;
   cnt_type  cnt_ff, cnt_in;

   // scan results for the accepted word
   res_type  res_v [RES_MAX];
   nres_type nres_v;
   logic     do_idle, do_adv, clear_v;
   logic     req_acc, rsp_acc;
   char_type c;
   logic     eos;
   pos_type  p, p1;
   res_type  head;

   assign req_stall = cnt_ff > ACCEPT_LIMIT;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = cnt_ff != '0;
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign c         = req_char_code;
   assign eos       = req_end_of_string;
   assign p         = char_pos_ff;
   assign p1        = p + pos_type'(1);

   // scan one character: next state and up to three result words
   always_comb begin
      mode_in      = mode_ff;
      dot_in       = dot_ff;
      tok_start_in = tok_start_ff;
      char_pos_in  = char_pos_ff;
      emitted_in   = emitted_ff;
      for (int i = 0; i < RES_MAX; i++) res_v[i] = '0;
      nres_v  = '0;
      do_idle = 1'b0;
      do_adv  = 1'b0;
      clear_v = 1'b0;
      if (req_acc) begin
         if (mode_ff == MODE_DROP) begin
            clear_v = eos;
         end else if (p == POS_MAX) begin
            // position overflow: flush pending token, then report
            if (mode_ff == MODE_NUM) begin
               res_v[nres_v] = make_res(KIND_NUMBER, ERR_NONE, tok_start_ff, p, '0);
               nres_v = nres_v + nres_type'(1);
            end else if (mode_ff == MODE_IDENT) begin
               res_v[nres_v] = make_res(KIND_IDENT, ERR_NONE, tok_start_ff, p, '0);
               nres_v = nres_v + nres_type'(1);
            end
            res_v[nres_v] = make_res(KIND_ERROR, ERR_LONG, p, p, '0);
            nres_v  = nres_v + nres_type'(1);
            mode_in = MODE_DROP;
            clear_v = eos;
         end else begin
            case (mode_ff)
               MODE_NUM: begin
                  if (is_digit(c)) begin
                     do_adv = 1'b1;
                  end else if (c == CH_DOT && !dot_ff) begin
                     dot_in = 1'b1;
                     do_adv = 1'b1;
                  end else begin
                     res_v[nres_v] = make_res(KIND_NUMBER, ERR_NONE, tok_start_ff, p, '0);
                     nres_v     = nres_v + nres_type'(1);
                     emitted_in = 1'b1;
                     mode_in    = MODE_IDLE;
                     do_idle    = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (is_tail(c)) begin
                     do_adv = 1'b1;
                  end else begin
                     res_v[nres_v] = make_res(KIND_IDENT, ERR_NONE, tok_start_ff, p, '0);
                     nres_v     = nres_v + nres_type'(1);
                     emitted_in = 1'b1;
                     mode_in    = MODE_IDLE;
                     do_idle    = 1'b1;
                  end
               end
               MODE_DOT: begin
                  if (is_digit(c)) begin
                     mode_in = MODE_NUM;
                     dot_in  = 1'b1;
                     do_adv  = 1'b1;
                  end else begin
                     // held dot not followed by a digit
                     res_v[nres_v] = make_res(KIND_ERROR, ERR_CHAR, tok_start_ff,
                                              tok_start_ff + pos_type'(1), CH_DOT);
                     nres_v  = nres_v + nres_type'(1);
                     mode_in = MODE_DROP;
                     clear_v = eos;
                  end
               end
               default: begin
                  do_idle = 1'b1;
               end
            endcase

            // start of a token from idle
            if (do_idle) begin
               if (is_space(c)) begin
                  do_adv = 1'b1;
               end else if (is_digit(c)) begin
                  mode_in      = MODE_NUM;
                  dot_in       = 1'b0;
                  tok_start_in = p;
                  do_adv       = 1'b1;
               end else if (c == CH_DOT) begin
                  if (eos) begin
                     res_v[nres_v] = make_res(KIND_ERROR, ERR_CHAR, p, p1, CH_DOT);
                     nres_v  = nres_v + nres_type'(1);
                     clear_v = 1'b1;
                  end else begin
                     mode_in      = MODE_DOT;
                     tok_start_in = p;
                     do_adv       = 1'b1;
                  end
               end else if (is_head(c)) begin
                  mode_in      = MODE_IDENT;
                  tok_start_in = p;
                  do_adv       = 1'b1;
               end else if (is_op(c)) begin
                  if (c == CH_SLASH) begin
                     res_v[nres_v] = make_res(emitted_in ? KIND_SLASH : KIND_CMD,
                                              ERR_NONE, p, p1, '0);
                  end else begin
                     res_v[nres_v] = make_res(op_kind(c), ERR_NONE, p, p1, '0);
                  end
                  nres_v     = nres_v + nres_type'(1);
                  emitted_in = 1'b1;
                  do_adv     = 1'b1;
               end else begin
                  res_v[nres_v] = make_res(KIND_ERROR, ERR_CHAR, p, p1, c);
                  nres_v  = nres_v + nres_type'(1);
                  mode_in = MODE_DROP;
                  clear_v = eos;
               end
            end

            // advance position; close out the string on its last character
            if (do_adv) begin
               char_pos_in = p1;
               if (eos) begin
                  if (mode_in == MODE_NUM) begin
                     res_v[nres_v] = make_res(KIND_NUMBER, ERR_NONE, tok_start_in, p1, '0);
                     nres_v = nres_v + nres_type'(1);
                  end else if (mode_in == MODE_IDENT) begin
                     res_v[nres_v] = make_res(KIND_IDENT, ERR_NONE, tok_start_in, p1, '0);
                     nres_v = nres_v + nres_type'(1);
                  end
                  res_v[nres_v] = make_res(KIND_END, ERR_NONE, p1, p1, '0);
                  nres_v  = nres_v + nres_type'(1);
                  clear_v = 1'b1;
               end
            end
         end

         // start a new string
         if (clear_v) begin
            mode_in      = MODE_IDLE;
            dot_in       = 1'b0;
            tok_start_in = '0;
            char_pos_in  = '0;
            emitted_in   = 1'b0;
         end
      end
      if (nres_v != '0) res_v[nres_v - nres_type'(1)].last = 1'b1;
   end

   // queue pointers and fill
   assign wr_ptr_in = wr_ptr_ff + ptr_type'(nres_v);
   assign rd_ptr_in = rd_ptr_ff + ptr_type'(rsp_acc);
   assign cnt_in    = cnt_ff + cnt_type'(nres_v) - cnt_type'(rsp_acc);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         dot_ff       <= 1'b0;
         tok_start_ff <= '0;
         char_pos_ff  <= '0;
         emitted_ff   <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
      end else begin
         mode_ff      <= mode_in;
         dot_ff       <= dot_in;
         tok_start_ff <= tok_start_in;
         char_pos_ff  <= char_pos_in;
         emitted_ff   <= emitted_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         cnt_ff       <= cnt_in;
      end
   end

   // write result words into the queue
   always_ff @(posedge clock) begin
      for (int i = 0; i < RES_MAX; i++) begin
         if (nres_type'(i) < nres_v) begin
            fifo_ff[wr_ptr_ff + ptr_type'(i)] <= res_v[i];
         end
      end
   end

   // drive the head word
   assign head            = fifo_ff[rd_ptr_ff];
   assign rsp_token_kind  = head.kind;
   assign rsp_error_code  = head.err;
   assign rsp_start_pos   = head.start_pos;
   assign rsp_end_pos     = head.end_pos;
   assign rsp_bad_char    = head.bad;
   assign rsp_last_of_run = head.last;

   `ETS_ASSERT_RST(a_reset_clears, reset |=> (cnt_ff == '0) && (mode_ff == MODE_IDLE), "reset did not clear queue or scanner")
   `ETS_ASSERT(a_fill_bound, cnt_ff <= cnt_type'(FIFO_DEPTH), "result queue overfilled")
   `ETS_ASSERT(a_eos_restarts, (req_acc && req_end_of_string) |=> (mode_ff == MODE_IDLE) && (char_pos_ff == '0) && !emitted_ff, "string end did not restart scanner")
   `ETS_ASSERT(a_error_ends_run, (rsp_valid && (rsp_token_kind == KIND_ERROR)) |-> rsp_last_of_run, "error word not last of its run")
   `ETS_ASSERT(a_drop_silent, (req_acc && (mode_ff == MODE_DROP)) |-> (nres_v == '0), "word produced while dropping")

endmodule

// File: tb/expression_token_scanner_top_tb.sv
// Testbench for expression_token_scanner_top: drives character words, predicts token words
// with a scoreboard class and checks every word on the rsp_ channel in order.
// Depends on ets_pkg and the expression_token_scanner_top RTL.
`timescale 1ns / 1ps

module expression_token_scanner_top_tb;
   import ets_pkg::*;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code     = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic [3:0] rsp_token_kind;
   logic [1:0] rsp_error_code;
   logic [15:0] rsp_start_pos;
   logic [15:0] rsp_end_pos;
   logic [7:0] rsp_bad_char;
   logic       rsp_last_of_run;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned chars_sent         = 0;
   char_type    line_buf[$];

   typedef struct {
      kind_type    kind;
      err_type     err;
      logic [15:0] start_pos;
      logic [15:0] end_pos;
      char_type    bad;
      logic        last;
   } token_word_type;

   // Token predictor plus the queue of token words still owed by the block
   class token_scoreboard;
      token_word_type expected_words[$];
      token_word_type run_words[$];
      int unsigned errors;
      int unsigned word_count;
      mode_type    mode;
      logic        dot_seen;
      pos_type     tok_start;
      pos_type     char_pos;
      logic        tok_emitted;

      function new();
         errors     = 0;
         word_count = 0;
         restart();
      endfunction

      function void restart();
         mode        = MODE_IDLE;
         dot_seen    = 1'b0;
         tok_start   = '0;
         char_pos    = '0;
         tok_emitted = 1'b0;
      endfunction

      function bit digit(char_type c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function bit word_head(char_type c);
         return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                c == CH_UNDER;
      endfunction

      function bit blank(char_type c);
         return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
      endfunction

      // map an operator character to its kind; returns 0 for anything else
      function bit op_lookup(char_type c, output kind_type k);
         op_lookup = 1'b1;
         case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_CARET:  k = KIND_CARET;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_COMMA:  k = KIND_COMMA;
            CH_COLON:  k = KIND_COLON;
            CH_EQUAL:  k = KIND_EQUAL;
            CH_SLASH:  k = tok_emitted ? KIND_SLASH : KIND_CMD;
            default: begin
               k         = KIND_ERROR;
               op_lookup = 1'b0;
            end
         endcase
      endfunction

      function void emit(kind_type k, err_type e, pos_type s, pos_type f, char_type b);
         token_word_type w;
         w.kind      = k;
         w.err       = e;
         w.start_pos = s[15:0];
         w.end_pos   = f[15:0];
         w.bad       = b;
         w.last      = 1'b0;
         run_words.insert(run_words.size(), w);
         if (k <= KIND_SLASH) tok_emitted = 1'b1;
      endfunction

      // close a pending number or identifier at position f
      function void flush_token(pos_type f);
         if (mode == MODE_NUM) emit(KIND_NUMBER, ERR_NONE, tok_start, f, 8'h00);
         else if (mode == MODE_IDENT) emit(KIND_IDENT, ERR_NONE, tok_start, f, 8'h00);
         mode = MODE_IDLE;
      endfunction

      // after an error: drop until end of string, or start over at once
      function void fail_over(bit eos);
         if (eos) restart();
         else mode = MODE_DROP;
      endfunction

      // predict the token words caused by one accepted character word
      function void note_char(char_type c, bit eos);
         pos_type  p;
         bit       scan_idle;
         bit       failed;
         kind_type k;
         p         = char_pos;
         scan_idle = 1'b1;
         failed    = 1'b0;
         run_words.delete();
         if (mode == MODE_DROP) begin
            if (eos) restart();
            return;
         end
         if (p == POS_MAX) begin
            // string too long: a held dot vanishes, a pending token goes out first
            if (mode == MODE_DOT) mode = MODE_IDLE;
            flush_token(p);
            emit(KIND_ERROR, ERR_LONG, p, p, 8'h00);
            fail_over(eos);
            scan_idle = 1'b0;
            failed    = 1'b1;
         end else begin
            case (mode)
               MODE_NUM: begin
                  if (digit(c)) scan_idle = 1'b0;
                  else if (c == CH_DOT && !dot_seen) begin
                     dot_seen  = 1'b1;
                     scan_idle = 1'b0;
                  end else flush_token(p);
               end
               MODE_IDENT: begin
                  if (word_head(c) || digit(c)) scan_idle = 1'b0;
                  else flush_token(p);
               end
               MODE_DOT: begin
                  if (digit(c)) begin
                     mode      = MODE_NUM;
                     dot_seen  = 1'b1;
                     scan_idle = 1'b0;
                  end else begin
                     emit(KIND_ERROR, ERR_CHAR, tok_start, tok_start + 1'b1, CH_DOT);
                     fail_over(eos);
                     failed = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         // idle scan of the current character
         if (!failed && scan_idle) begin
            if (blank(c)) begin
            end else if (digit(c)) begin
               mode      = MODE_NUM;
               dot_seen  = 1'b0;
               tok_start = p;
            end else if (c == CH_DOT) begin
               if (eos) begin
                  emit(KIND_ERROR, ERR_CHAR, p, p + 1'b1, CH_DOT);
                  restart();
                  failed = 1'b1;
               end else begin
                  mode      = MODE_DOT;
                  tok_start = p;
               end
            end else if (word_head(c)) begin
               mode      = MODE_IDENT;
               tok_start = p;
            end else if (op_lookup(c, k)) begin
               emit(k, ERR_NONE, p, p + 1'b1, 8'h00);
            end else begin
               emit(KIND_ERROR, ERR_CHAR, p, p + 1'b1, c);
               fail_over(eos);
               failed = 1'b1;
            end
         end
         // advance the position; the last character closes the string
         if (!failed) begin
            char_pos = p + 1'b1;
            if (eos) begin
               flush_token(p + 1'b1);
               emit(KIND_END, ERR_NONE, p + 1'b1, p + 1'b1, 8'h00);
               restart();
            end
         end
         if (run_words.size() > 0) run_words[run_words.size() - 1].last = 1'b1;
         foreach (run_words[i]) expected_words.insert(expected_words.size(), run_words[i]);
      endfunction

      function int outstanding();
         return expected_words.size();
      endfunction

      task report(string msg);
         errors++;
         $display("[tb] %0t mismatch: %s", $realtime, msg);
      endtask

      // compare one accepted token word with the oldest expectation
      task check_word(kind_type k, err_type e, logic [15:0] s, logic [15:0] f,
                      char_type b, logic l);
         token_word_type w;
         if (expected_words.size() == 0) begin
            report($sformatf("word %0d kind %0d arrived with nothing expected", word_count, k));
         end else begin
            w = expected_words.pop_front();
            if (k !== w.kind)
               report($sformatf("word %0d kind %0d, want %0d", word_count, k, w.kind));
            if (e !== w.err)
               report($sformatf("word %0d error_code %0d, want %0d", word_count, e, w.err));
            if (s !== w.start_pos)
               report($sformatf("word %0d start_pos %0d, want %0d", word_count, s, w.start_pos));
            if (f !== w.end_pos)
               report($sformatf("word %0d end_pos %0d, want %0d", word_count, f, w.end_pos));
            if (b !== w.bad)
               report($sformatf("word %0d bad_char %h, want %h", word_count, b, w.bad));
            if (l !== w.last)
               report($sformatf("word %0d last_of_run %b, want %b", word_count, l, w.last));
         end
         word_count++;
      endtask
   endclass

   token_scoreboard sb = new();

   expression_token_scanner_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_error_code    (rsp_error_code),
      .rsp_start_pos     (rsp_start_pos),
      .rsp_end_pos       (rsp_end_pos),
      .rsp_bad_char      (rsp_bad_char),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall = !reset && ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Check each token word taken at a rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_word(rsp_token_kind, rsp_error_code, rsp_start_pos, rsp_end_pos,
                       rsp_bad_char, rsp_last_of_run);
   end

   // Append one character to the string being built
   function automatic void add_char(input char_type c);
      line_buf.insert(line_buf.size(), c);
   endfunction

   // Send one character word, with random gaps ahead of it; entered at a falling edge
   task automatic send_char(input char_type c, input bit eos);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_char_code     = c;
      req_end_of_string = eos;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_char(c, eos);
      chars_sent++;
      @(negedge clock);
   endtask

   // Send the buffered string, marking its last character
   task automatic send_line();
      foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
      send_line();
   endtask

   function automatic char_type rand_head();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return char_type'(CH_LO_A + r);
      if (r < 52) return char_type'(CH_UP_A + (r - 26));
      return CH_UNDER;
   endfunction

   function automatic char_type rand_digit();
      return char_type'(CH_ZERO + $urandom_range(0, 9));
   endfunction

   function automatic char_type rand_blank();
      if ($urandom_range(0, 1)) return CH_SPACE;
      return char_type'($urandom_range(CH_TAB, CH_CR));
   endfunction

   // Build a mostly well-formed expression with random content
   task automatic build_expression();
      char_type ops[10];
      int       n;
      int       r;
      ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_CARET, CH_LPAREN, CH_RPAREN,
              CH_COMMA, CH_COLON, CH_EQUAL, CH_SLASH};
      n   = $urandom_range(1, 6);
      if ($urandom_range(0, 4) == 0) add_char(CH_SLASH);
      for (int t = 0; t < n; t++) begin
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) add_char(rand_blank());
         r = $urandom_range(0, 99);
         if (r < 35) begin
            if ($urandom_range(0, 9) == 0) add_char(CH_DOT);
            repeat ($urandom_range(1, 3)) add_char(rand_digit());
            if ($urandom_range(0, 2) == 0) begin
               add_char(CH_DOT);
               repeat ($urandom_range(0, 2)) add_char(rand_digit());
            end
         end else if (r < 60) begin
            add_char(rand_head());
            repeat ($urandom_range(0, 3))
               add_char($urandom_range(0, 3) == 0 ? rand_digit() : rand_head());
         end else if (r < 92) begin
            add_char(ops[$urandom_range(0, 9)]);
         end else if (r < 96) begin
            add_char(CH_DOT);
         end else begin
            case ($urandom_range(0, 2))
               0: add_char(char_type'($urandom_range(128, 255)));
               1: add_char(char_type'($urandom_range(0, 8)));
               default: add_char(char_type'($urandom_range(8'h21, 8'h27)));
            endcase
         end
      end
      send_line();
   endtask

   // Main sequence
   initial begin
      int unsigned target;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed strings: operators, slash kinds, held dot, errors
      send_text("/x /.5");
      send_text("(+-*^),:=");
      send_text("1.5.");
      send_text("a\t.zq");
      add_char(8'hFF);
      send_line();
      add_char("Q");
      add_char(8'h00);
      send_line();

      // random traffic in four idling phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
            default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
         endcase
         target = chars_sent + 45;
         while (chars_sent < target) begin
            if ($urandom_range(0, 99) < 80) begin
               build_expression();
            end else begin
               // noise: random bytes with random string ends
               repeat ($urandom_range(1, 5))
                  send_char(char_type'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
               send_char(char_type'($urandom_range(0, 255)), $urandom_range(0, 1) == 1);
            end
         end
      end

      // drain the remaining token words
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[expression_token_scanner_top] OK");
      end else begin
         $display("[expression_token_scanner_top] ERROR");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("[expression_token_scanner_top] ERROR");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ets_pkg.sv
hw/rtl/expression_token_scanner_top.sv
tb/expression_token_scanner_top_tb.sv
